@@ rtl/core/gbn_pkg.sv @@
// shared constants, codes and sequence arithmetic for the go-back-n endpoint
// depends on nothing
package gbn_pkg;

  localparam int MAX_SEQ = 7;
  localparam int SEQ_W   = 3;
  localparam int PAY_W   = 32;
  localparam logic [SEQ_W:0] SEQ_MOD = (SEQ_W + 1)'(MAX_SEQ + 1);

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [PAY_W-1:0] pay_t;

  typedef enum logic [1:0] {
    REQ_HOST    = 2'd0,
    REQ_FRAME   = 2'd1,
    REQ_CKERR   = 2'd2,
    REQ_TIMEOUT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_SEND    = 3'd0,
    KIND_DELIVER = 3'd1,
    KIND_STOP    = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_t;

  function automatic seq_t seq_inc(input seq_t s);
    return (s == SEQ_W'(MAX_SEQ)) ? '0 : s + SEQ_W'(1);
  endfunction

  function automatic seq_t seq_add(input seq_t a, input seq_t b);
    logic [SEQ_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum >= SEQ_MOD) ? SEQ_W'(sum - SEQ_MOD) : sum[SEQ_W-1:0];
  endfunction

  // circular distance from a forward to b
  function automatic seq_t seq_dist(input seq_t a, input seq_t b);
    logic [SEQ_W:0] diff;
    diff = (b >= a) ? ({1'b0, b} - {1'b0, a}) : ({1'b0, b} + SEQ_MOD - {1'b0, a});
    return diff[SEQ_W-1:0];
  endfunction

  function automatic seq_t seq_prev(input seq_t s);
    return (s == '0) ? SEQ_W'(MAX_SEQ) : s - SEQ_W'(1);
  endfunction

endpackage

@@ rtl/core/go_back_n_link_endpoint_top.sv @@
// go-back-n link endpoint: window state, packet store and result sequencer
// depends on gbn_pkg
// an accepted item is decoded into pending registers, then into the output register once it is free
// throughput: host packet, checksum error: 1 result; frame arrival: up to 8 results;
//   timeout: up to 7 results read from the packet store, one result per cycle
//   while out_ready holds; next item taken the cycle after its last result is loaded
// reset: sequence numbers and outstanding count cleared; packet store not cleared
module go_back_n_link_endpoint_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [gbn_pkg::PAY_W-1:0]  in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]  in_seq,
  input  logic [gbn_pkg::SEQ_W-1:0]  in_ack,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_kind,
  output logic [gbn_pkg::SEQ_W-1:0]  out_seq,
  output logic [gbn_pkg::SEQ_W-1:0]  out_ack,
  output logic [gbn_pkg::PAY_W-1:0]  out_payload,
  output logic                       out_host_enable,
  output logic                       out_last_result
);

  typedef enum logic [1:0] {ST_IDLE, ST_SINGLE, ST_STOP, ST_RESEND} state_t;

  state_t               state_r;
  gbn_pkg::seq_t        nts_r, exp_r, oldest_r, count_r;
  gbn_pkg::seq_t        iter_r, cnt_r;
  logic                 he_r;
  gbn_pkg::kind_t       p_kind_r;
  gbn_pkg::seq_t        p_seq_r, p_ack_r;
  gbn_pkg::pay_t        p_payload_r;
  logic                 p_last_r;

  state_t               state_nxt;
  logic                 he_nxt;
  gbn_pkg::kind_t       p_kind_nxt;
  gbn_pkg::seq_t        p_seq_nxt, p_ack_nxt;
  gbn_pkg::pay_t        p_payload_nxt;
  logic                 p_last_nxt;

  logic                 out_valid_r;
  gbn_pkg::kind_t       out_kind_r;
  gbn_pkg::seq_t        out_seq_r, out_ack_r;
  gbn_pkg::pay_t        out_payload_r;
  logic                 out_he_r, out_last_r;

  gbn_pkg::pay_t        mem [2**gbn_pkg::SEQ_W];
  gbn_pkg::pay_t        rdata_r;
  gbn_pkg::seq_t        rd_addr;
  logic                 wr_en;

  logic                 accept, slot_free, load, full, deliver, retire;
  gbn_pkg::seq_t        ack_span, retire_n, ack_val;

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign slot_free = !out_valid_r || out_ready;
  assign load      = (state_r != ST_IDLE) && slot_free;
  assign full      = count_r >= gbn_pkg::SEQ_W'(gbn_pkg::MAX_SEQ);
  assign deliver   = in_seq == exp_r;
  assign ack_span  = gbn_pkg::seq_dist(oldest_r, in_ack);
  assign retire    = (count_r != '0) && (in_ack <= gbn_pkg::SEQ_W'(gbn_pkg::MAX_SEQ))
                     && (ack_span < count_r);
  assign retire_n  = ack_span + gbn_pkg::SEQ_W'(1);
  assign ack_val   = gbn_pkg::seq_prev(exp_r);
  assign wr_en     = accept && (gbn_pkg::req_t'(in_req_type) == gbn_pkg::REQ_HOST) && !full;

  always_comb begin
    unique case (state_r)
      ST_IDLE:   rd_addr = oldest_r;
      ST_RESEND: rd_addr = slot_free ? gbn_pkg::seq_inc(iter_r) : iter_r;
      default:   rd_addr = iter_r;
    endcase
  end

  // decode of an item taken in idle
  always_comb begin
    p_kind_nxt    = gbn_pkg::KIND_NONE;
    p_seq_nxt     = '0;
    p_ack_nxt     = '0;
    p_payload_nxt = '0;
    p_last_nxt    = 1'b1;
    he_nxt        = !full;
    state_nxt     = ST_SINGLE;
    unique case (gbn_pkg::req_t'(in_req_type))
      gbn_pkg::REQ_HOST: begin
        if (full) begin
          p_kind_nxt = gbn_pkg::KIND_REJECT;
        end else begin
          p_kind_nxt    = gbn_pkg::KIND_SEND;
          p_seq_nxt     = nts_r;
          p_ack_nxt     = ack_val;
          p_payload_nxt = in_payload;
          he_nxt        = (count_r + gbn_pkg::SEQ_W'(1))
                          < gbn_pkg::SEQ_W'(gbn_pkg::MAX_SEQ);
        end
      end
      gbn_pkg::REQ_FRAME: begin
        if (deliver) begin
          p_kind_nxt    = gbn_pkg::KIND_DELIVER;
          p_seq_nxt     = in_seq;
          p_payload_nxt = in_payload;
          p_last_nxt    = !retire;
        end
        if (retire) begin
          he_nxt = 1'b1;
          if (!deliver) begin
            state_nxt = ST_STOP;
          end
        end
      end
      gbn_pkg::REQ_CKERR: begin
      end
      gbn_pkg::REQ_TIMEOUT: begin
        if (count_r != '0) begin
          state_nxt = ST_RESEND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[nts_r] <= in_payload;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nts_r       <= '0;
      exp_r       <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      cnt_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            p_kind_r    <= p_kind_nxt;
            p_seq_r     <= p_seq_nxt;
            p_ack_r     <= p_ack_nxt;
            p_payload_r <= p_payload_nxt;
            p_last_r    <= p_last_nxt;
            he_r        <= he_nxt;
            state_r     <= state_nxt;
            unique case (gbn_pkg::req_t'(in_req_type))
              gbn_pkg::REQ_HOST: begin
                if (!full) begin
                  nts_r   <= gbn_pkg::seq_inc(nts_r);
                  count_r <= count_r + gbn_pkg::SEQ_W'(1);
                end
              end
              gbn_pkg::REQ_FRAME: begin
                if (deliver) begin
                  exp_r <= gbn_pkg::seq_inc(exp_r);
                end
                if (retire) begin
                  iter_r   <= oldest_r;
                  cnt_r    <= retire_n;
                  oldest_r <= gbn_pkg::seq_add(oldest_r, retire_n);
                  count_r  <= count_r - retire_n;
                end
              end
              gbn_pkg::REQ_CKERR: begin
              end
              gbn_pkg::REQ_TIMEOUT: begin
                if (count_r != '0) begin
                  iter_r <= oldest_r;
                  cnt_r  <= count_r;
                end
              end
            endcase
          end
        end
        ST_SINGLE: begin
          if (slot_free) begin
            out_kind_r    <= p_kind_r;
            out_seq_r     <= p_seq_r;
            out_ack_r     <= p_ack_r;
            out_payload_r <= p_payload_r;
            out_he_r      <= he_r;
            out_last_r    <= p_last_r;
            state_r       <= p_last_r ? ST_IDLE : ST_STOP;
          end
        end
        ST_STOP, ST_RESEND: begin
          if (slot_free) begin
            out_seq_r   <= iter_r;
            out_he_r    <= he_r;
            out_last_r  <= cnt_r == gbn_pkg::SEQ_W'(1);
            if (state_r == ST_STOP) begin
              out_kind_r    <= gbn_pkg::KIND_STOP;
              out_ack_r     <= '0;
              out_payload_r <= '0;
            end else begin
              out_kind_r    <= gbn_pkg::KIND_SEND;
              out_ack_r     <= ack_val;
              out_payload_r <= rdata_r;
            end
            iter_r <= gbn_pkg::seq_inc(iter_r);
            cnt_r  <= cnt_r - gbn_pkg::SEQ_W'(1);
            if (cnt_r == gbn_pkg::SEQ_W'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready        = state_r == ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_seq         = out_seq_r;
  assign out_ack         = out_ack_r;
  assign out_payload     = out_payload_r;
  assign out_host_enable = out_he_r;
  assign out_last_result = out_last_r;

endmodule

@@ test/gbn_link_checker.sv @@
`timescale 1ns / 1ps
// checker for the go-back-n link endpoint: mirrors the window state, predicts result items
// and compares them field by field with the result channel; depends on gbn_pkg
module gbn_link_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                in_req_type,
  input  logic [gbn_pkg::PAY_W-1:0] in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0] in_seq,
  input  logic [gbn_pkg::SEQ_W-1:0] in_ack,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [2:0]                out_kind,
  input  logic [gbn_pkg::SEQ_W-1:0] out_seq,
  input  logic [gbn_pkg::SEQ_W-1:0] out_ack,
  input  logic [gbn_pkg::PAY_W-1:0] out_payload,
  input  logic                      out_host_enable,
  input  logic                      out_last_result,
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);
  import gbn_pkg::*;

  typedef struct packed {
    kind_t kind;
    seq_t  seq;
    seq_t  ack;
    pay_t  payload;
    logic  host_en;
    logic  last;
  } link_result_t;

  link_result_t expected_q[$];
  seq_t         tx_next;
  seq_t         tx_oldest;
  seq_t         rx_expected;
  logic [2:0]   in_flight;
  pay_t         sent_store [0:MAX_SEQ];
  int           mismatches;
  int           results_checked;

  assign fail_count = mismatches;
  assign checked    = results_checked;

  // ack covers lo when it lies in the circular span [lo, hi)
  function automatic logic ack_in_window(seq_t lo, seq_t a, seq_t hi);
    return (lo <= a && a < hi) || (hi < lo && lo <= a) || (a < hi && hi < lo);
  endfunction

  function automatic link_result_t make_result(kind_t k, seq_t s, seq_t a, pay_t p);
    link_result_t r;
    r.kind    = k;
    r.seq     = s;
    r.ack     = a;
    r.payload = p;
    r.host_en = 1'b0;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic predict_item(req_t req, pay_t pay, seq_t seq, seq_t ack);
    link_result_t batch[$];
    seq_t         s;
    int           i;
    case (req)
      REQ_HOST: begin
        if (in_flight >= MAX_SEQ) begin
          batch.push_back(make_result(KIND_REJECT, '0, '0, '0));
        end else begin
          sent_store[tx_next] = pay;
          in_flight++;
          batch.push_back(make_result(KIND_SEND, tx_next, seq_t'(rx_expected + MAX_SEQ), pay));
          tx_next++;
        end
      end
      REQ_FRAME: begin
        if (seq == rx_expected) begin
          batch.push_back(make_result(KIND_DELIVER, seq, '0, pay));
          rx_expected++;
        end
        while (in_flight > 0 && ack_in_window(tx_oldest, ack, tx_next)) begin
          batch.push_back(make_result(KIND_STOP, tx_oldest, '0, '0));
          in_flight--;
          tx_oldest++;
        end
      end
      REQ_TIMEOUT: begin
        s = tx_oldest;
        for (i = 0; i < in_flight; i++) begin
          batch.push_back(make_result(KIND_SEND, s, seq_t'(rx_expected + MAX_SEQ),
                                      sent_store[s]));
          s++;
        end
      end
      default: ;
    endcase
    if (batch.size() == 0) batch.push_back(make_result(KIND_NONE, '0, '0, '0));
    foreach (batch[j]) begin
      batch[j].host_en = (in_flight < MAX_SEQ);
      batch[j].last    = (j == batch.size() - 1);
      expected_q.push_back(batch[j]);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    link_result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result item: kind %0d seq %0d", out_kind, out_seq);
      mismatches++;
    end else begin
      want = expected_q.pop_front();
      results_checked++;
      check_field("out_kind", want.kind, out_kind);
      check_field("out_seq", want.seq, out_seq);
      check_field("out_ack", want.ack, out_ack);
      check_field("out_payload", want.payload, out_payload);
      check_field("out_host_enable", want.host_en, out_host_enable);
      check_field("out_last_result", want.last, out_last_result);
    end
  endtask

  initial begin
    mismatches      = 0;
    results_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      tx_next     = '0;
      tx_oldest   = '0;
      rx_expected = '0;
      in_flight   = '0;
      foreach (sent_store[k]) sent_store[k] = '0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) predict_item(req_t'(in_req_type), in_payload, in_seq, in_ack);
    end
    pending <= expected_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// top of the go-back-n link endpoint testbench: clock, reset, item stimulus with bursts
// and receiver stalls, watchdog and verdict; depends on gbn_pkg and gbn_link_checker
module tb_top;
  import gbn_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 100;
  localparam int STALL_HOLD   = 200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  pay_t       in_payload;
  seq_t       in_seq;
  seq_t       in_ack;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_kind;
  seq_t       out_seq;
  seq_t       out_ack;
  pay_t       out_payload;
  logic       out_host_enable;
  logic       out_last_result;

  int   fail_count;
  int   pending;
  int   checked;
  int   stall_cmd;
  int   items_sent;
  int   idle_run;
  seq_t peer_seq;

  go_back_n_link_endpoint_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_payload      (in_payload),
    .in_seq          (in_seq),
    .in_ack          (in_ack),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_seq         (out_seq),
    .out_ack         (out_ack),
    .out_payload     (out_payload),
    .out_host_enable (out_host_enable),
    .out_last_result (out_last_result)
  );

  gbn_link_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_payload      (in_payload),
    .in_seq          (in_seq),
    .in_ack          (in_ack),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_seq         (out_seq),
    .out_ack         (out_ack),
    .out_payload     (out_payload),
    .out_host_enable (out_host_enable),
    .out_last_result (out_last_result),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $error("watchdog: no item accepted for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: segments of always-ready, random and fixed-pattern stalls, plus long hold-offs
  initial begin
    int seg_left;
    int mode;
    int phase;
    int hold_left;
    int stall_seen;
    seg_left   = 0;
    mode       = 0;
    phase      = 0;
    hold_left  = 0;
    stall_seen = 0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_cmd != stall_seen) begin
        stall_seen = stall_cmd;
        hold_left  = STALL_HOLD;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ((phase % 5) < 3);
        endcase
      end
    end
  end

  task automatic send_item(req_t req, pay_t pay, seq_t seq, seq_t ack);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_payload  <= pay;
    in_seq      <= seq;
    in_ack      <= ack;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (req == REQ_FRAME && seq == peer_seq) peer_seq++;
  endtask

  task automatic sender_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int   pick;
    req_t req;
    pay_t pay;
    seq_t seq;
    pick = $urandom_range(0, 99);
    if (pick < 45) req = REQ_HOST;
    else if (pick < 80) req = REQ_FRAME;
    else if (pick < 85) req = REQ_CKERR;
    else req = REQ_TIMEOUT;
    case ($urandom_range(0, 9))
      0:       pay = '0;
      1:       pay = '1;
      default: pay = $urandom();
    endcase
    // mostly in-order frames so deliveries keep happening
    if (req == REQ_FRAME && $urandom_range(0, 3) != 0) seq = peer_seq;
    else seq = seq_t'($urandom_range(0, MAX_SEQ));
    send_item(req, pay, seq, seq_t'($urandom_range(0, MAX_SEQ)));
  endtask

  initial begin
    int n;
    int burst;
    bit paused;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_HOST;
    in_payload  <= '0;
    in_seq      <= '0;
    in_ack      <= '0;
    stall_cmd   <= 0;
    peer_seq    = '0;
    items_sent  = 0;
    paused      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty window: nothing to resend, checksum error, out-of-order frame
    send_item(REQ_TIMEOUT, 32'h1234_5678, 3'd7, 3'd7);
    send_item(REQ_CKERR, '1, 3'd7, 3'd7);
    send_item(REQ_FRAME, 32'hDEAD_BEEF, 3'd1, 3'd0);
    // fill the window, then one more is rejected
    send_item(REQ_HOST, '0, 3'd0, 3'd0);
    send_item(REQ_HOST, '1, 3'd7, 3'd7);
    repeat (5) send_item(REQ_HOST, $urandom(), 3'd0, 3'd0);
    send_item(REQ_HOST, 32'hCAFE_F00D, 3'd0, 3'd0);
    send_item(REQ_CKERR, '0, 3'd0, 3'd0);
    // full resend from the oldest
    send_item(REQ_TIMEOUT, '0, 3'd0, 3'd0);
    // ack outside the window, then acks that retire part and the rest
    send_item(REQ_FRAME, 32'hA5A5_A5A5, 3'd0, 3'd7);
    send_item(REQ_FRAME, 32'h5A5A_5A5A, 3'd1, 3'd2);
    send_item(REQ_FRAME, 32'h0F0F_0F0F, 3'd5, 3'd6);
    // wrap of the sequence space
    send_item(REQ_HOST, 32'h8000_0001, 3'd0, 3'd0);
    send_item(REQ_TIMEOUT, '0, 3'd0, 3'd0);
    send_item(REQ_FRAME, '1, 3'd2, 3'd7);
    send_item(REQ_TIMEOUT, '1, 3'd0, 3'd0);
    wait_drained();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        random_item();
        n++;
        if (n == 40) stall_cmd <= stall_cmd + 1;
      end
      if (n >= 40 && n < 60) begin
        // keep offering while the receiver holds off
      end else if (n >= 70 && !paused) begin
        wait_drained();
        paused = 1;
      end else begin
        sender_gap($urandom_range(0, 6));
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run summary: %0d input items sent, %0d result items checked", items_sent, checked);
    $display("covered full window, resends, ack bursts, a long output stall and a drained pause");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/gbn_pkg.sv
rtl/core/go_back_n_link_endpoint_top.sv
test/gbn_link_checker.sv
test/tb_top.sv
